### rtl/fifohs_pkg.sv
// Package for the FIFO with in-place heap-sort reorder.
// Holds the command and status codes and the value width.
// No dependencies.
package fifohs_pkg;

   localparam int unsigned VALUE_W = 32;

   typedef enum logic [1:0] {
      CMD_ENQ     = 2'd0,
      CMD_DEQ     = 2'd1,
      CMD_REORDER = 2'd2,
      CMD_RSVD    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

endpackage

### rtl/fifo_with_heap_sort_reorder.sv
// Top level: bounded FIFO of signed 32-bit values with a heap-sort reorder command.
// Uses fifohs_pkg for command and status codes.
// Values live in one single-port-read, single-port-write ring memory.
//
// Channel  | Dir | Ports                         | Word contents
// ---------+-----+-------------------------------+----------------------------------------
// request  | in  | req_tvalid/tready/tdata/tuser | tdata: value; tuser: command
// response | out | rsp_tvalid/tready/tdata/tuser | tdata: out_value, occupancy; tuser: status
//
// Enqueue, reorder and a reserved command have their response registered at the accept edge.
// Dequeue issues the memory read at accept and registers its response in S_DEQ once the
// response register is free. After its response, reorder runs a heap sort on the memory:
// each sift level reads the children, compares and writes back; each sift also fetches the
// start node or swaps root and last, and parks the value, all through the single memory read
// port. No request is accepted until it finishes. Reset is synchronous and clears head,
// count and control; the memory has no reset and no clearing pass. A request is taken only
// when the response register is empty or is being drained in the same cycle.
module fifo_with_heap_sort_reorder #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // request: tdata[31:0] value (signed); tuser[1:0] command
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,
   input  logic [1:0]                    req_tuser,
   // response: tdata[31:0] out_value (signed), tdata[32 +: CW] occupancy, rest zero;
   // tuser[1:0] status
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [((32 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic [1:0]                    rsp_tuser
);

   localparam int unsigned VW      = fifohs_pkg::VALUE_W;
   localparam int unsigned AW      = $clog2(DEPTH);
   localparam int unsigned CW      = $clog2(DEPTH + 1);
   localparam int unsigned OW      = CW + 1;           // heap offsets incl. child indexes
   localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);
   localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DEQ,      // dequeue read data arriving
      S_NODE,     // read sift start node
      S_LC,       // node data arriving, read left child
      S_RC,       // left child arriving, read right child
      S_CMP,      // pick smallest, move it up, descend
      S_FIN,      // park sifted value at its final node
      S_SW0,      // read root
      S_SW1,      // root arriving, read last
      S_SW2       // swap root and last, start sift from root
   } state_type;

   // ring memory
   logic [VW-1:0] ring_store_ff [DEPTH];
   logic [VW-1:0] rd_data_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [VW-1:0] wr_data;

   // control and response registers
   state_type              state_ff, state_in;
   logic [AW-1:0]          head_ff, head_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]          rsp_value_ff, rsp_value_in;
   fifohs_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [CW-1:0]          rsp_occ_ff, rsp_occ_in;

   // heap sort sequencer
   logic          build_ff, build_in;    // 1: heap build phase, 0: extraction phase
   logic [OW-1:0] start_ff, start_in;    // current build start node
   logic [OW-1:0] k_ff, k_in;            // extraction position
   logic [OW-1:0] len_ff, len_in;        // heap length for the running sift
   logic [OW-1:0] node_ff, node_in;      // node holding the sifted value
   logic [OW-1:0] pick_ff, pick_in;      // smaller of node and left child
   logic          rc_ok_ff, rc_ok_in;
   logic [VW-1:0] cur_ff, cur_in;        // value being sifted down
   logic [VW-1:0] best_ff, best_in;

   logic                req_acc;
   fifohs_pkg::cmd_type req_cmd;
   logic          sift_done;
   logic          child_go;
   logic [OW-1:0] child_node;
   logic [OW-1:0] child_lc;
   logic [OW-1:0] lc;
   logic [OW-1:0] rc;
   logic          sel_rc;
   logic [VW-1:0] sel_val;
   logic [OW-1:0] sel_node;

   // heap offset -> memory slot, offset is always below DEPTH here
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [OW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, head} + {1'b0, off[AW-1:0]};
      if (sum >= DEPTH_A) begin
         sum = sum - DEPTH_A;
      end
      return sum[AW-1:0];
   endfunction

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_acc    = req_tvalid && req_tready;
   assign req_cmd    = fifohs_pkg::cmd_type'(req_tuser);

   assign lc       = (node_ff << 1) + OW'(1);
   assign rc       = (node_ff << 1) + OW'(2);
   assign sel_rc   = rc_ok_ff && ($signed(rd_data_ff) < $signed(best_ff));
   assign sel_val  = sel_rc ? rd_data_ff : best_ff;
   assign sel_node = sel_rc ? rc : pick_ff;
   assign child_lc = (child_node << 1) + OW'(1);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      build_in      = build_ff;
      start_in      = start_ff;
      k_in          = k_ff;
      len_in        = len_ff;
      node_in       = node_ff;
      pick_in       = pick_ff;
      rc_ok_in      = rc_ok_ff;
      cur_in        = cur_ff;
      best_in       = best_ff;
      rd_en         = 1'b0;
      rd_addr       = head_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_of(head_ff, node_ff);
      wr_data       = cur_ff;
      sift_done     = 1'b0;
      child_go      = 1'b0;
      child_node    = node_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = fifohs_pkg::ST_OK;
               rsp_occ_in    = count_ff;
               case (req_cmd)
                  fifohs_pkg::CMD_ENQ: begin
                     if (count_ff == CNT_MAX) begin
                        rsp_status_in = fifohs_pkg::ST_FULL;
                     end else begin
                        wr_en      = 1'b1;
                        wr_addr    = slot_of(head_ff, OW'(count_ff));
                        wr_data    = req_tdata;
                        count_in   = count_ff + CW'(1);
                        rsp_occ_in = count_ff + CW'(1);
                     end
                  end
                  fifohs_pkg::CMD_DEQ: begin
                     if (count_ff == '0) begin
                        rsp_status_in = fifohs_pkg::ST_EMPTY;
                     end else begin
                        // response waits for the memory read
                        rsp_valid_in = 1'b0;
                        rd_en        = 1'b1;
                        rd_addr      = head_ff;
                        head_in      = slot_of(head_ff, OW'(1));
                        count_in     = count_ff - CW'(1);
                        state_in     = S_DEQ;
                     end
                  end
                  fifohs_pkg::CMD_REORDER: begin
                     if (count_ff >= CW'(2)) begin
                        build_in = 1'b1;
                        len_in   = OW'(count_ff);
                        start_in = OW'(count_ff >> 1) - OW'(1);
                        node_in  = OW'(count_ff >> 1) - OW'(1);
                        state_in = S_NODE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DEQ: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_data_ff;
               rsp_status_in = fifohs_pkg::ST_OK;
               rsp_occ_in    = count_ff;
               state_in      = S_IDLE;
            end
         end
         S_NODE: begin
            rd_en    = 1'b1;
            rd_addr  = slot_of(head_ff, node_ff);
            state_in = S_LC;
         end
         S_LC: begin
            cur_in   = rd_data_ff;
            child_go = 1'b1;
         end
         S_RC: begin
            if ($signed(rd_data_ff) < $signed(cur_ff)) begin
               best_in = rd_data_ff;
               pick_in = lc;
            end else begin
               best_in = cur_ff;
               pick_in = node_ff;
            end
            rc_ok_in = rc < len_ff;
            if (rc < len_ff) begin
               rd_en   = 1'b1;
               rd_addr = slot_of(head_ff, rc);
            end
            state_in = S_CMP;
         end
         S_CMP: begin
            wr_en = 1'b1;
            if (sel_node == node_ff) begin
               sift_done = 1'b1;
            end else begin
               // smaller child moves up, sifted value descends
               wr_data    = sel_val;
               node_in    = sel_node;
               child_node = sel_node;
               child_go   = 1'b1;
            end
         end
         S_FIN: begin
            wr_en     = 1'b1;
            sift_done = 1'b1;
         end
         S_SW0: begin
            rd_en    = 1'b1;
            rd_addr  = slot_of(head_ff, '0);
            state_in = S_SW1;
         end
         S_SW1: begin
            cur_in   = rd_data_ff;
            rd_en    = 1'b1;
            rd_addr  = slot_of(head_ff, k_ff);
            state_in = S_SW2;
         end
         S_SW2: begin
            // old root goes to position k, old last value sifts from the root
            wr_en      = 1'b1;
            wr_addr    = slot_of(head_ff, k_ff);
            wr_data    = cur_ff;
            cur_in     = rd_data_ff;
            node_in    = '0;
            len_in     = k_ff;
            child_node = '0;
            child_go   = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (child_go) begin
         if (child_lc < len_in) begin
            rd_en    = 1'b1;
            rd_addr  = slot_of(head_ff, child_lc);
            state_in = S_RC;
         end else begin
            state_in = S_FIN;
         end
      end

      if (sift_done) begin
         if (build_ff) begin
            if (start_ff != '0) begin
               start_in = start_ff - OW'(1);
               node_in  = start_ff - OW'(1);
               state_in = S_NODE;
            end else begin
               build_in = 1'b0;
               k_in     = len_ff - OW'(1);
               state_in = S_SW0;
            end
         end else if (k_ff > OW'(1)) begin
            k_in     = k_ff - OW'(1);
            state_in = S_SW0;
         end else begin
            state_in = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ring_store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         build_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         build_ff     <= build_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
      start_ff      <= start_in;
      k_ff          <= k_in;
      len_ff        <= len_in;
      node_ff       <= node_in;
      pick_ff       <= pick_in;
      rc_ok_ff      <= rc_ok_in;
      cur_ff        <= cur_in;
      best_ff       <= best_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;

   always_comb begin
      rsp_tdata            = '0;
      rsp_tdata[VW-1:0]    = rsp_value_ff;
      rsp_tdata[VW +: CW]  = rsp_occ_ff;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("entry count above depth");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff < DEPTH_A[AW-1:0] || DEPTH_A[AW])
      else $error("head slot out of range");

   a_busy_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |=> $stable(count_ff) && $stable(head_ff))
      else $error("queue pointers moved while busy");

   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_cmd == fifohs_pkg::CMD_DEQ && count_ff != '0)
      |=> count_ff == $past(count_ff) - CW'(1) && state_ff == S_DEQ)
      else $error("dequeue did not pop one entry");
`endif

endmodule
